// ----- hw/rtl/rgb_to_hsv_pixel_converter_defines.svh -----
`ifndef RGB_TO_HSV_PIXEL_CONVERTER_DEFINES_SVH
`define RGB_TO_HSV_PIXEL_CONVERTER_DEFINES_SVH

`ifndef SYNTHESIS

`define RTHSV_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rthsv check failed");

`define RTHSV_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rthsv check failed");

`else

`define RTHSV_ASSERT_NOW(lbl, clk, rst, ante, cons)

`define RTHSV_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- hw/rtl/rthsv_pkg.sv -----
package rthsv_pkg;

   localparam int unsigned CHAN_W        = 8;
   localparam int unsigned NUM_W         = 2 * CHAN_W;
   localparam int unsigned BITS_PER_STEP = 2;
   localparam int unsigned DIV_STEPS     = CHAN_W / BITS_PER_STEP;
   localparam int unsigned STAGES        = DIV_STEPS + 2;

   localparam logic [CHAN_W-1:0] FULL_SCALE   = 8'd255;
   localparam logic [CHAN_W-1:0] HUE_STEP     = 8'd43;
   localparam logic [CHAN_W-1:0] OFS_RED      = 8'd0;
   localparam logic [CHAN_W-1:0] OFS_RED_WRAP = 8'd255;
   localparam logic [CHAN_W-1:0] OFS_GREEN    = 8'd85;
   localparam logic [CHAN_W-1:0] OFS_BLUE     = 8'd170;

   typedef logic [CHAN_W-1:0] chan_type;

   typedef struct packed {
      chan_type rem;
      chan_type rest;
      chan_type quot;
   } div_lane_type;

   typedef struct packed {
      chan_type     hi;
      chan_type     span;
      chan_type     offset;
      logic         neg;
      div_lane_type sat;
      div_lane_type hue;
   } pipe_type;

endpackage

// ----- hw/rtl/rthsv_ifs.sv -----
interface rthsv_req_if;
   logic               valid;
   logic               ready;
   rthsv_pkg::chan_type red;
   rthsv_pkg::chan_type green;
   rthsv_pkg::chan_type blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface rthsv_rsp_if;
   logic               valid;
   logic               ready;
   rthsv_pkg::chan_type hue;
   rthsv_pkg::chan_type saturation;
   rthsv_pkg::chan_type brightness;

   modport source (output valid, output hue, output saturation, output brightness,
                   input ready);
   modport sink (input valid, input hue, input saturation, input brightness,
                 output ready);
endinterface

// ----- hw/rtl/rthsv_classify.sv -----
module rthsv_classify (
   input  logic                clock,
   input  logic                load,
   input  rthsv_pkg::chan_type red,
   input  rthsv_pkg::chan_type green,
   input  rthsv_pkg::chan_type blue,
   output rthsv_pkg::pipe_type stage_out
);
   import rthsv_pkg::*;

   pipe_type             stage_ff;
   pipe_type             stage_in;
   chan_type             hi;
   chan_type             lo;
   chan_type             span;
   chan_type             pos_c;
   chan_type             neg_c;
   chan_type             mag;
   logic                 red_top;
   logic                 green_top;
   logic                 minus;
   logic [NUM_W-1:0]     num_s;
   logic [NUM_W-1:0]     num_h;

   always_comb begin
      red_top   = (red >= green) && (red >= blue);
      green_top = !red_top && (green >= blue);
      if (red_top) begin
         hi    = red;
         pos_c = green;
         neg_c = blue;
      end else if (green_top) begin
         hi    = green;
         pos_c = blue;
         neg_c = red;
      end else begin
         hi    = blue;
         pos_c = red;
         neg_c = green;
      end
      lo = red;
      if (green < lo) lo = green;
      if (blue < lo) lo = blue;
      span  = hi - lo;
      minus = pos_c < neg_c;
      mag   = minus ? (neg_c - pos_c) : (pos_c - neg_c);
      num_s = NUM_W'(span) * NUM_W'(FULL_SCALE);
      num_h = NUM_W'(mag) * NUM_W'(HUE_STEP);

      stage_in.hi   = hi;
      stage_in.span = span;
      stage_in.neg  = minus;
      if (red_top) begin
         stage_in.offset = minus ? OFS_RED_WRAP : OFS_RED;
      end else if (green_top) begin
         stage_in.offset = OFS_GREEN;
      end else begin
         stage_in.offset = OFS_BLUE;
      end
      stage_in.sat.rem  = num_s[NUM_W-1:CHAN_W];
      stage_in.sat.rest = num_s[CHAN_W-1:0];
      stage_in.sat.quot = '0;
      stage_in.hue.rem  = num_h[NUM_W-1:CHAN_W];
      stage_in.hue.rest = num_h[CHAN_W-1:0];
      stage_in.hue.quot = '0;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_out = stage_ff;

endmodule

// ----- hw/rtl/rthsv_div_step.sv -----
module rthsv_div_step (
   input  logic                clock,
   input  logic                load,
   input  rthsv_pkg::pipe_type stage_prev,
   output rthsv_pkg::pipe_type stage_out
);
   import rthsv_pkg::*;

   pipe_type stage_ff;
   pipe_type stage_in;

   function automatic div_lane_type lane_step(div_lane_type lane, chan_type divisor);
      logic [CHAN_W:0] trial;
      div_lane_type    nxt;
      nxt = lane;
      for (int i = 0; i < BITS_PER_STEP; i++) begin
         trial    = {nxt.rem, nxt.rest[CHAN_W-1]};
         nxt.rest = nxt.rest << 1;
         nxt.quot = {nxt.quot[CHAN_W-2:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            trial       = trial - {1'b0, divisor};
            nxt.quot[0] = 1'b1;
         end
         nxt.rem = trial[CHAN_W-1:0];
      end
      return nxt;
   endfunction

   always_comb begin
      stage_in     = stage_prev;
      stage_in.sat = lane_step(stage_prev.sat, stage_prev.hi);
      stage_in.hue = lane_step(stage_prev.hue, stage_prev.span);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_out = stage_ff;

endmodule

// ----- hw/rtl/rthsv_finish.sv -----
module rthsv_finish (
   input  logic                clock,
   input  logic                load,
   input  rthsv_pkg::pipe_type stage_prev,
   output rthsv_pkg::chan_type hue,
   output rthsv_pkg::chan_type saturation,
   output rthsv_pkg::chan_type brightness
);
   import rthsv_pkg::*;

   chan_type hue_ff;
   chan_type hue_in;
   chan_type sat_ff;
   chan_type sat_in;
   chan_type bright_ff;
   chan_type round_up;

   always_comb begin
      round_up = chan_type'(stage_prev.hue.rem != '0);
      if (stage_prev.span == '0) begin
         hue_in = '0;
      end else if (stage_prev.neg) begin
         hue_in = stage_prev.offset - stage_prev.hue.quot - round_up;
      end else begin
         hue_in = stage_prev.offset + stage_prev.hue.quot;
      end
      sat_in = (stage_prev.hi == '0) ? '0 : stage_prev.sat.quot;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         hue_ff    <= hue_in;
         sat_ff    <= sat_in;
         bright_ff <= stage_prev.hi;
      end
   end

   assign hue        = hue_ff;
   assign saturation = sat_ff;
   assign brightness = bright_ff;

endmodule

// ----- hw/rtl/rgb_to_hsv_pixel_converter.sv -----
// One pixel per cycle unless rsp_bus.ready holds back a full pipeline;
// six register stages (classify, four two-bit restoring divide steps
// shared by saturation and hue, finish) lie between req and rsp beats.
// Reset is synchronous and clears the stage valid bits only; the datapath
// registers are not reset.
`include "rgb_to_hsv_pixel_converter_defines.svh"

module rgb_to_hsv_pixel_converter (
   input logic         clock,
   input logic         reset,
   rthsv_req_if.sink   req_bus,
   rthsv_rsp_if.source rsp_bus
);
   import rthsv_pkg::*;

   logic [STAGES-1:0] pipe_valid_ff;
   logic [STAGES-1:0] pipe_valid_in;
   logic [STAGES-1:0] advance;
   pipe_type          stage_q [DIV_STEPS+1];

   always_comb begin
      advance[STAGES-1] = !pipe_valid_ff[STAGES-1] || rsp_bus.ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         advance[k] = !pipe_valid_ff[k] || advance[k+1];
      end
      pipe_valid_in = {pipe_valid_ff[STAGES-2:0], req_bus.valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_valid_ff <= '0;
      end else begin
         for (int k = 0; k < STAGES; k++) begin
            if (advance[k]) begin
               pipe_valid_ff[k] <= pipe_valid_in[k];
            end
         end
      end
   end

   rthsv_classify u_classify (
      .clock     (clock),
      .load      (advance[0]),
      .red       (req_bus.red),
      .green     (req_bus.green),
      .blue      (req_bus.blue),
      .stage_out (stage_q[0])
   );

   for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
      rthsv_div_step u_div_step (
         .clock      (clock),
         .load       (advance[g+1]),
         .stage_prev (stage_q[g]),
         .stage_out  (stage_q[g+1])
      );
   end

   rthsv_finish u_finish (
      .clock      (clock),
      .load       (advance[STAGES-1]),
      .stage_prev (stage_q[DIV_STEPS]),
      .hue        (rsp_bus.hue),
      .saturation (rsp_bus.saturation),
      .brightness (rsp_bus.brightness)
   );

   assign req_bus.ready = advance[0];
   assign rsp_bus.valid = pipe_valid_ff[STAGES-1];

   `RTHSV_ASSERT_NEXT(a_accept_lands, clock, reset, req_bus.valid && req_bus.ready, pipe_valid_ff[0])
   `RTHSV_ASSERT_NOW(a_hue_range, clock, reset, rsp_bus.valid, rsp_bus.hue != 8'd255)
   `RTHSV_ASSERT_NOW(a_black_pixel, clock, reset, rsp_bus.valid && rsp_bus.brightness == 8'd0, rsp_bus.saturation == 8'd0 && rsp_bus.hue == 8'd0)

endmodule
